>>> hdl/nonce_replay_cache_assert.svh
// ----------------------------------------------------------------------------
// nonce_replay_cache_assert.svh
// Assertion macros shared by the replay cache RTL.
// ----------------------------------------------------------------------------
`ifndef NONCE_REPLAY_CACHE_ASSERT_SVH
`define NONCE_REPLAY_CACHE_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define NRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/nrc_pkg.sv
// ----------------------------------------------------------------------------
// nrc_pkg
// Types and constants of the nonce replay cache.
// ----------------------------------------------------------------------------
package nrc_pkg;

    localparam int LEN_W     = 7;
    localparam int TIME_W    = 32;
    localparam int TTL_W     = 16;
    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = 8;
    localparam int WORDS_W   = WORD_W * NUM_WORDS;

    // slave tdata layout: nonce_length, nonce_word_0..7, now_seconds
    localparam int LEN_LSB   = 0;
    localparam int WORDS_LSB = LEN_LSB + LEN_W;
    localparam int NOW_LSB   = WORDS_LSB + WORDS_W;
    localparam int IN_BITS   = NOW_LSB + TIME_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [TTL_W-1:0] TTL_RESET = 16'd300;

    localparam logic KIND_CHECK   = 1'b0;
    localparam logic KIND_CONSUME = 1'b1;

    localparam logic REG_TTL = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

endpackage

>>> hdl/nrc_entry_mem.sv
// ----------------------------------------------------------------------------
// nrc_entry_mem
// Entry store: one row per ring slot, one write and one registered read.
// ----------------------------------------------------------------------------
module nrc_entry_mem #(
    parameter int DEPTH = 32,
    parameter int ROW_W = 551
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [ROW_W-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [ROW_W-1:0]                       o_rdata
);

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/nonce_replay_cache.sv
// ----------------------------------------------------------------------------
// nonce_replay_cache
// Replay cache of recent nonces with time-to-live eviction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one transaction per request; tuser[0] selects
//   check (0) or consume (1). A consume of nonzero length stores the
//   nonce, its clamped length and now_seconds in the next ring slot.
//   A check with length zero is answered not fresh without a scan. Other
//   checks scan the ring one entry per cycle from slot 0, evicting entries
//   older than ttl_seconds, and stop at the first live matching entry.
//   The master stream returns is_fresh in tdata[0] for each check. A
//   consume gives no result and leaves the slave ready; a check holds off
//   new requests until its result is loaded into the output register. The
//   scan pace is set by the entry memory's single registered read port.
//   Reset clears all valid bits, the write slot and the output register,
//   and sets ttl_seconds to 300; no memory clearing pass is needed.
//   A stalled master holds the result in the output register; the next
//   request is taken while that result waits, and a second result then
//   waits in the control logic until the register frees.
//   ttl_seconds sits at APB byte address 0.
// ----------------------------------------------------------------------------
`include "nonce_replay_cache_assert.svh"

module nonce_replay_cache #(
    parameter int HISTORY_DEPTH   = 32,
    parameter int MAX_NONCE_BYTES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave: tuser = kind; tdata = nonce_length, nonce_word_0..7, now_seconds
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [nrc_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [0:0]                    i_s_tuser,
    // master: tdata = is_fresh
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [nrc_pkg::M_TDATA_W-1:0] o_m_tdata,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nrc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [nrc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [nrc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    import nrc_pkg::*;

    localparam int AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int NB    = MAX_NONCE_BYTES * 8;
    localparam int ROW_W = TIME_W + LEN_W + NB;

    // input unpacking
    logic [LEN_W-1:0]   w_len;
    logic [WORDS_W-1:0] w_words;
    logic [TIME_W-1:0]  w_now;
    logic               w_kind;
    logic [NB-1:0]      w_masked;
    logic [LEN_W-1:0]   w_len_clamp;

    assign w_len   = i_s_tdata[LEN_LSB +: LEN_W];
    assign w_words = i_s_tdata[WORDS_LSB +: WORDS_W];
    assign w_now   = i_s_tdata[NOW_LSB +: TIME_W];
    assign w_kind  = i_s_tuser[0];

    always_comb begin
        for (int b = 0; b < MAX_NONCE_BYTES; b++) begin
            w_masked[b*8 +: 8] = (LEN_W'(b) < w_len) ? w_words[b*8 +: 8] : 8'd0;
        end
    end

    assign w_len_clamp = (w_len > LEN_W'(MAX_NONCE_BYTES)) ?
                         LEN_W'(MAX_NONCE_BYTES) : w_len;

    // registers
    t_state                   r_state, n_state;
    logic [HISTORY_DEPTH-1:0] r_valid, n_valid;
    logic [AW-1:0]            r_wr_slot, n_wr_slot;
    logic [CW-1:0]            r_rd_idx, n_rd_idx;
    logic [AW-1:0]            r_ev_idx, n_ev_idx;
    logic                     r_pend, n_pend;
    logic                     r_res, n_res;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_fresh, n_out_fresh;
    logic [TTL_W-1:0]         r_ttl;
    logic [LEN_W-1:0]         r_len, n_len;
    logic [NB-1:0]            r_nonce, n_nonce;
    logic [TIME_W-1:0]        r_now, n_now;

    // memory interface
    logic               w_we;
    logic [ROW_W-1:0]   w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [ROW_W-1:0]   w_rdata;
    logic [TIME_W-1:0]  w_rd_time;
    logic [LEN_W-1:0]   w_rd_len;
    logic [NB-1:0]      w_rd_bytes;
    logic [TIME_W:0]    w_age;
    logic               w_expired;
    logic               w_match;
    logic               w_s_acc;
    logic               w_cfg_wr;

    assign w_wdata = {w_now, w_len_clamp, w_masked};
    assign w_raddr = r_rd_idx[AW-1:0];

    nrc_entry_mem #(
        .DEPTH (HISTORY_DEPTH),
        .ROW_W (ROW_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wr_slot),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_time  = w_rdata[ROW_W-1 -: TIME_W];
    assign w_rd_len   = w_rdata[NB +: LEN_W];
    assign w_rd_bytes = w_rdata[NB-1:0];

    // signed age over 33 bits; negative never expires
    assign w_age     = {1'b0, r_now} - {1'b0, w_rd_time};
    assign w_expired = !w_age[TIME_W] && (w_age[TIME_W-1:0] > {16'd0, r_ttl});
    assign w_match   = (w_rd_len == r_len) && (w_rd_bytes == r_nonce);

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_wr_slot   = r_wr_slot;
        n_rd_idx    = r_rd_idx;
        n_ev_idx    = r_ev_idx;
        n_pend      = r_pend;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_fresh = r_out_fresh;
        n_len       = r_len;
        n_nonce     = r_nonce;
        n_now       = r_now;
        w_we        = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    if (w_kind == KIND_CONSUME) begin
                        if (w_len != '0) begin
                            w_we               = 1'b1;
                            n_valid[r_wr_slot] = 1'b1;
                            n_wr_slot = (r_wr_slot == AW'(HISTORY_DEPTH - 1)) ?
                                        '0 : r_wr_slot + AW'(1);
                        end
                    end else if (w_len == '0) begin
                        n_res   = 1'b0;
                        n_state = ST_HOLD;
                    end else begin
                        n_len    = w_len;
                        n_nonce  = w_masked;
                        n_now    = w_now;
                        n_rd_idx = '0;
                        n_pend   = 1'b0;
                        n_state  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rd_idx < CW'(HISTORY_DEPTH)) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_ev_idx = r_rd_idx[AW-1:0];
                    n_pend   = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_valid[r_ev_idx] && w_expired) begin
                        n_valid[r_ev_idx] = 1'b0;
                    end
                    if (r_valid[r_ev_idx] && !w_expired && w_match) begin
                        n_res   = 1'b0;
                        n_pend  = 1'b0;
                        n_state = ST_HOLD;
                    end else if (r_ev_idx == AW'(HISTORY_DEPTH - 1)) begin
                        n_res   = 1'b1;
                        n_pend  = 1'b0;
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_fresh = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_wr_slot   <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_wr_slot   <= n_wr_slot;
            r_rd_idx    <= n_rd_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx    <= n_ev_idx;
        r_res       <= n_res;
        r_out_fresh <= n_out_fresh;
        r_len       <= n_len;
        r_nonce     <= n_nonce;
        r_now       <= n_now;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - 1){1'b0}}, r_out_fresh};

    // configuration
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TTL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= TTL_RESET;
        end else if (w_cfg_wr) begin
            r_ttl <= pwdata[TTL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TTL) ? {{(APB_DATA_W - TTL_W){1'b0}}, r_ttl} : '0;

    // assertions
    `NRC_ASSERT_IMP(a_eval_in_scan, r_pend, r_state == ST_SCAN,
        "entry evaluated outside of a scan")
    `NRC_ASSERT_IMP(a_rd_idx_range, r_state == ST_SCAN, r_rd_idx <= CW'(HISTORY_DEPTH),
        "scan read index past the ring")
    `NRC_ASSERT_NXT(a_slot_advance,
        w_s_acc && (w_kind == KIND_CONSUME) && (w_len != '0),
        r_valid[$past(r_wr_slot)] && (r_wr_slot == (($past(r_wr_slot) ==
            AW'(HISTORY_DEPTH - 1)) ? '0 : $past(r_wr_slot) + AW'(1))),
        "consume did not fill its slot and advance the ring")

endmodule
